@@ rtl/twrm_pkg.sv @@
// ----------------------------------------------------------------------------
// twrm_pkg
// Shared types and constants of the two-way record merge.
// ----------------------------------------------------------------------------
package twrm_pkg;

  // Default configuration.
  localparam int unsigned BufDepthDef    = 32;
  localparam int unsigned SymbolCharsDef = 8;

  // Fixed field widths.
  localparam int unsigned TimeW = 64;
  localparam int unsigned SymW  = 64;
  localparam int unsigned TagW  = 32;

  // Request codes.
  typedef enum logic {
    REQ_PUSH  = 1'b0,
    REQ_FLUSH = 1'b1
  } twrm_req_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_FETCH,
    ST_EMIT
  } twrm_state_e;

  // Merge key: timestamp first, then the zero-extended symbol.
  typedef struct packed {
    logic [TimeW-1:0] ts;
    logic [SymW-1:0]  sym;
  } twrm_key_t;

endpackage

@@ rtl/twrm_ram.sv @@
// ----------------------------------------------------------------------------
// twrm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module twrm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ rtl/twrm_cmp.sv @@
// ----------------------------------------------------------------------------
// twrm_cmp
// Shared key comparator: decides which stream head leaves first.
// ----------------------------------------------------------------------------
module twrm_cmp (
  input  twrm_pkg::twrm_key_t key0_i,
  input  twrm_pkg::twrm_key_t key1_i,
  output logic                zero_first_o
);

  // Stream zero wins only on a strictly smaller (timestamp, symbol) pair.
  assign zero_first_o = (key0_i < key1_i);

endmodule

@@ rtl/two_way_record_merge.sv @@
// ----------------------------------------------------------------------------
// two_way_record_merge
// Merges two individually sorted record streams into one sorted stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request at a time: a push of a record into
//   the buffer of its stream, or a flush that drains both buffers. The
//   output channel returns merged records; last marks the final record that
//   a request causes, and dropped flags a push that found its buffer full.
//   A request is taken only while the sequencer is idle. A push with nothing
//   to merge returns no record and goes through the select state back to
//   idle. Every merged record goes through the select and present states,
//   plus a fetch of the next head of the stream it left, all through the one
//   read port of the record RAM and the one shared key comparator; a dropped
//   push goes from idle straight to the present state. Records leave through
//   an output register, so a stalled receiver simply holds the sequencer in
//   its present state with nothing lost. Reset empties both buffers at once;
//   the record RAM needs no clearing: only written entries are ever read.
// ----------------------------------------------------------------------------
module two_way_record_merge #(
  parameter int unsigned BUF_DEPTH    = twrm_pkg::BufDepthDef,
  parameter int unsigned SYMBOL_CHARS = twrm_pkg::SymbolCharsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic                       source_i,
  input  logic [twrm_pkg::TimeW-1:0] timestamp_i,
  input  logic [twrm_pkg::SymW-1:0]  symbol_i,
  input  logic [twrm_pkg::TagW-1:0]  tag_i,
  // Result channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_source_o,
  output logic [twrm_pkg::TimeW-1:0] out_timestamp_o,
  output logic [twrm_pkg::SymW-1:0]  out_symbol_o,
  output logic [twrm_pkg::TagW-1:0]  out_tag_o,
  output logic                       dropped_o,
  output logic                       last_o
);

  import twrm_pkg::*;

  localparam int unsigned SymBits  = 8 * SYMBOL_CHARS;
  localparam int unsigned PtrW     = $clog2(BUF_DEPTH);
  localparam int unsigned CntW     = $clog2(BUF_DEPTH + 1);
  localparam int unsigned SumW     = CntW + 1;
  localparam int unsigned RamDepth = 2 * BUF_DEPTH;
  localparam int unsigned AddrW    = $clog2(RamDepth);
  localparam int unsigned RecW     = TimeW + SymBits + TagW;

  localparam logic [CntW-1:0]  FullCnt = CntW'(BUF_DEPTH);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(BUF_DEPTH - 1);
  localparam logic [SumW-1:0]  DepSum  = SumW'(BUF_DEPTH);
  localparam logic [AddrW-1:0] Side1At = AddrW'(BUF_DEPTH);

  // Control state.
  twrm_state_e     state_q, state_d;
  logic            flush_q, flush_d;
  logic            fetch_side_q, fetch_side_d;
  logic [PtrW-1:0] head0_q, head0_d, head1_q, head1_d;
  logic [CntW-1:0] fill0_q, fill0_d, fill1_q, fill1_d;
  logic            hv0_q, hv0_d, hv1_q, hv1_d;

  // Cached stream heads and the output register.
  logic [RecW-1:0]    h0_q, h0_d, h1_q, h1_d;
  logic               out_src_q, out_src_d;
  logic [TimeW-1:0]   out_ts_q, out_ts_d;
  logic [SymBits-1:0] out_sym_q, out_sym_d;
  logic [TagW-1:0]    out_tag_q, out_tag_d;
  logic               out_drop_q, out_drop_d;
  logic               out_last_q, out_last_d;

  // RAM port signals.
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [RecW-1:0]  wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [RecW-1:0]  rd_data;

  // Comparator signals.
  twrm_key_t key0, key1;
  logic      zero_first;

  // Tail slot of the pushed stream, wrapped into its half of the RAM.
  logic [PtrW-1:0] src_head;
  logic [CntW-1:0] src_fill;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail_idx;

  assign src_head = source_i ? head1_q : head0_q;
  assign src_fill = source_i ? fill1_q : fill0_q;

  always_comb begin
    tail_sum = SumW'(src_head) + SumW'(src_fill);
    if (tail_sum >= DepSum) begin
      tail_sum = tail_sum - DepSum;
    end
    tail_idx = tail_sum[PtrW-1:0];
  end

  assign wr_addr = source_i ? (Side1At + AddrW'(tail_idx)) : AddrW'(tail_idx);
  assign wr_data = {timestamp_i, symbol_i[SymBits-1:0], tag_i};

  // Record storage for both streams.
  twrm_ram #(
    .Width (RecW),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Key compare of the two cached heads.
  assign key0.ts  = h0_q[RecW-1 -: TimeW];
  assign key0.sym = SymW'(h0_q[TagW +: SymBits]);
  assign key1.ts  = h1_q[RecW-1 -: TimeW];
  assign key1.sym = SymW'(h1_q[TagW +: SymBits]);

  twrm_cmp u_cmp (
    .key0_i       (key0),
    .key1_i       (key1),
    .zero_first_o (zero_first)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: next state, buffer bookkeeping and output loading.
  always_comb begin
    logic            both;
    logic            do_pop;
    logic            pop_side;
    logic [CntW-1:0] f0n;
    logic [CntW-1:0] f1n;

    state_d      = state_q;
    flush_d      = flush_q;
    fetch_side_d = fetch_side_q;
    head0_d      = head0_q;
    head1_d      = head1_q;
    fill0_d      = fill0_q;
    fill1_d      = fill1_q;
    hv0_d        = hv0_q;
    hv1_d        = hv1_q;
    h0_d         = h0_q;
    h1_d         = h1_q;
    out_src_d    = out_src_q;
    out_ts_d     = out_ts_q;
    out_sym_d    = out_sym_q;
    out_tag_d    = out_tag_q;
    out_drop_d   = out_drop_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    both         = (fill0_q != '0) && (fill1_q != '0);
    do_pop       = 1'b0;
    pop_side     = 1'b0;
    f0n          = fill0_q;
    f1n          = fill1_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          flush_d = (req_type_i == REQ_FLUSH);
          hv0_d   = 1'b0;
          hv1_d   = 1'b0;
          if (req_type_i == REQ_PUSH && src_fill == FullCnt) begin
            // Full buffer: report the record back as dropped.
            out_src_d  = source_i;
            out_ts_d   = timestamp_i;
            out_sym_d  = symbol_i[SymBits-1:0];
            out_tag_d  = tag_i;
            out_drop_d = 1'b1;
            out_last_d = 1'b1;
            state_d    = ST_EMIT;
          end else begin
            if (req_type_i == REQ_PUSH) begin
              wr_en = 1'b1;
              if (source_i) begin
                fill1_d = fill1_q + 1'b1;
              end else begin
                fill0_d = fill0_q + 1'b1;
              end
            end
            state_d = ST_SEL;
          end
        end
      end

      ST_SEL: begin
        // Fetch a missing head first, then pick the side that leaves.
        if (both) begin
          if (!hv0_q) begin
            rd_en        = 1'b1;
            rd_addr      = AddrW'(head0_q);
            fetch_side_d = 1'b0;
            state_d      = ST_FETCH;
          end else if (!hv1_q) begin
            rd_en        = 1'b1;
            rd_addr      = Side1At + AddrW'(head1_q);
            fetch_side_d = 1'b1;
            state_d      = ST_FETCH;
          end else begin
            do_pop   = 1'b1;
            pop_side = !zero_first;
          end
        end else if (flush_q && fill0_q != '0) begin
          if (!hv0_q) begin
            rd_en        = 1'b1;
            rd_addr      = AddrW'(head0_q);
            fetch_side_d = 1'b0;
            state_d      = ST_FETCH;
          end else begin
            do_pop   = 1'b1;
            pop_side = 1'b0;
          end
        end else if (flush_q && fill1_q != '0) begin
          if (!hv1_q) begin
            rd_en        = 1'b1;
            rd_addr      = Side1At + AddrW'(head1_q);
            fetch_side_d = 1'b1;
            state_d      = ST_FETCH;
          end else begin
            do_pop   = 1'b1;
            pop_side = 1'b1;
          end
        end else begin
          state_d = ST_IDLE;
        end

        if (do_pop) begin
          out_drop_d = 1'b0;
          out_src_d  = pop_side;
          if (pop_side) begin
            out_ts_d  = h1_q[RecW-1 -: TimeW];
            out_sym_d = h1_q[TagW +: SymBits];
            out_tag_d = h1_q[TagW-1:0];
            head1_d   = (head1_q == LastPtr) ? '0 : head1_q + 1'b1;
            f1n       = fill1_q - 1'b1;
            hv1_d     = 1'b0;
          end else begin
            out_ts_d  = h0_q[RecW-1 -: TimeW];
            out_sym_d = h0_q[TagW +: SymBits];
            out_tag_d = h0_q[TagW-1:0];
            head0_d   = (head0_q == LastPtr) ? '0 : head0_q + 1'b1;
            f0n       = fill0_q - 1'b1;
            hv0_d     = 1'b0;
          end
          fill0_d = f0n;
          fill1_d = f1n;
          // Last when nothing further would be emitted for this request.
          out_last_d = !(((f0n != '0) && (f1n != '0)) ||
                         (flush_q && ((f0n != '0) || (f1n != '0))));
          state_d = ST_EMIT;
        end
      end

      ST_FETCH: begin
        // Read data of the head requested in the select state.
        if (fetch_side_q) begin
          h1_d  = rd_data;
          hv1_d = 1'b1;
        end else begin
          h0_d  = rd_data;
          hv0_d = 1'b1;
        end
        state_d = ST_SEL;
      end

      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = out_last_q ? ST_IDLE : ST_SEL;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flush_q      <= 1'b0;
      fetch_side_q <= 1'b0;
      head0_q      <= '0;
      head1_q      <= '0;
      fill0_q      <= '0;
      fill1_q      <= '0;
      hv0_q        <= 1'b0;
      hv1_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      flush_q      <= flush_d;
      fetch_side_q <= fetch_side_d;
      head0_q      <= head0_d;
      head1_q      <= head1_d;
      fill0_q      <= fill0_d;
      fill1_q      <= fill1_d;
      hv0_q        <= hv0_d;
      hv1_q        <= hv1_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    h0_q       <= h0_d;
    h1_q       <= h1_d;
    out_src_q  <= out_src_d;
    out_ts_q   <= out_ts_d;
    out_sym_q  <= out_sym_d;
    out_tag_q  <= out_tag_d;
    out_drop_q <= out_drop_d;
    out_last_q <= out_last_d;
  end

  // Result outputs.
  assign out_valid_o     = (state_q == ST_EMIT);
  assign out_source_o    = out_src_q;
  assign out_timestamp_o = out_ts_q;
  assign out_symbol_o    = SymW'(out_sym_q);
  assign out_tag_o       = out_tag_q;
  assign dropped_o       = out_drop_q;
  assign last_o          = out_last_q;

`ifndef SYNTHESIS
  // Neither buffer ever holds more than its depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill0_q <= FullCnt) && (fill1_q <= FullCnt))
    else $error("buffer fill count exceeds depth");

  // Between requests, at most one stream holds records.
  a_one_side_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((fill0_q == '0) || (fill1_q == '0)))
    else $error("both streams hold records while idle");

  // The final record of a request frees the input on the next cycle.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("input not ready after final record");

  // A dropped report is always the final record of its request.
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> last_o)
    else $error("dropped report without last");
`endif

endmodule
